[hdl/dahl_pkg.sv]
// ----------------------------------------------------------------------------
// dahl_pkg
// types, constants and helpers shared by the dose average history log
// ----------------------------------------------------------------------------
package dahl_pkg;

    localparam int HISTORY_POINTS_DEF = 64;
    localparam int WINDOW_PERIOD      = 5;
    localparam int SECS_RANGE         = 64;
    localparam int SECS_MULTS         = (SECS_RANGE - 1) / WINDOW_PERIOD + 1;
    localparam logic [7:0] COUNT_LIMIT = 8'd255;
    localparam int DIV_STEPS          = 32;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  seconds;
        logic [31:0] dose_sample;
        logic [31:0] date_now;
        logic [5:0]  entry_index;
    } in_t;

    typedef struct packed {
        logic [31:0] entry_dose;
        logic [31:0] entry_date;
        logic        changed;
    } out_t;

    typedef struct packed {
        logic [31:0] dose;
        logic [31:0] date;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROTATE,
        ST_FINISH
    } state_t;

    // true when the seconds value closes a window
    function automatic logic is_window_end(input logic [5:0] secs);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SECS_MULTS; i++) begin
            if (secs == 6'(i * WINDOW_PERIOD)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[hdl/dose_average_history_log.sv]
// ----------------------------------------------------------------------------
// dose_average_history_log
// averaged dose history with a live entry, closed windows kept in a cell chain
// ----------------------------------------------------------------------------
// One word is handled at a time. A tick that adds a sample or closes a window
// that holds samples runs the 32-step bit-serial divider. A read of entries 1
// to HISTORY_POINTS-1 circulates the whole cell chain once. Every other word
// goes straight to the finish state, where each result waits while the
// previous word is still held in the output register. The input is ready
// again in the cycle after the result is loaded. A new word is taken while
// the previous result still waits in the output register.
module dose_average_history_log
    import dahl_pkg::*;
#(
    parameter int HISTORY_POINTS = HISTORY_POINTS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int CW    = $clog2(HISTORY_POINTS);
    localparam int CELLS = HISTORY_POINTS - 1;

    state_t      state_reg, state_next;
    in_t         in_reg, in_next;
    logic        close_reg, close_next;
    logic [CW-1:0] rot_cnt_reg, rot_cnt_next;
    entry_t      pick_reg, pick_next;
    logic [31:0] live_dose_reg, live_dose_next;
    logic [31:0] live_date_reg, live_date_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] wdate_reg, wdate_next;
    logic        flag_reg, flag_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic        accept;
    logic        out_free;
    logic        win_end;
    logic [32:0] sum_ext;
    logic        add_ok;
    logic        idx_in_chain;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;
    logic        chain_push;
    logic        chain_shift;
    entry_t      push_entry;
    out_t        result;

    entry_t cell_d [1:CELLS];
    entry_t cell_q [1:CELLS];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign win_end  = is_window_end(s_data.seconds);
    assign sum_ext  = {1'b0, sum_reg} + {1'b0, s_data.dose_sample};
    assign add_ok   = (s_data.dose_sample != '0) && !sum_ext[32] && (count_reg != COUNT_LIMIT);
    assign idx_in_chain = (s_data.entry_index != '0) &&
                          (32'(s_data.entry_index) < 32'(HISTORY_POINTS));

    // cell chain
    genvar g;
    generate
        for (g = 1; g <= CELLS; g++) begin : g_cell
            if (g == 1) begin : g_head
                assign cell_d[g] = chain_push ? push_entry : cell_q[CELLS];
            end else begin : g_body
                assign cell_d[g] = cell_q[g-1];
            end
            dahl_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (chain_shift),
                .d_in     (cell_d[g]),
                .q        (cell_q[g])
            );
        end
    endgenerate

    dahl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority case (s_data.cmd)
                        CMD_TICK: begin
                            if (win_end) begin
                                state_next = (count_reg != '0) ? ST_DIVIDE : ST_FINISH;
                            end else begin
                                state_next = add_ok ? ST_DIVIDE : ST_FINISH;
                            end
                        end
                        CMD_READ: begin
                            state_next = idx_in_chain ? ST_ROTATE : ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_ROTATE: begin
                if (rot_cnt_reg == CW'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word
    always_comb begin
        result.entry_dose = live_dose_reg;
        result.entry_date = live_date_reg;
        result.changed    = flag_reg;
        if (in_reg.cmd == CMD_READ) begin
            if (in_reg.entry_index == '0) begin
                result.entry_dose = live_dose_reg;
                result.entry_date = live_date_reg;
            end else if (32'(in_reg.entry_index) >= 32'(HISTORY_POINTS)) begin
                result.entry_dose = '0;
                result.entry_date = '0;
            end else begin
                result.entry_dose = pick_reg.dose;
                result.entry_date = pick_reg.date;
            end
        end
    end

    // outputs and datapath
    always_comb begin
        in_next        = in_reg;
        close_next     = close_reg;
        rot_cnt_next   = rot_cnt_reg;
        pick_next      = pick_reg;
        live_dose_next = live_dose_reg;
        live_date_next = live_date_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        wdate_next     = wdate_reg;
        flag_next      = flag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        chain_push     = 1'b0;
        chain_shift    = 1'b0;
        push_entry     = '0;
        div_start      = (state_reg == ST_IDLE) && (state_next == ST_DIVIDE);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_next = s_data;
                    if (s_data.cmd == CMD_TICK) begin
                        close_next = win_end;
                        if (!win_end) begin
                            if (wdate_reg == '0) begin
                                wdate_next = s_data.date_now;
                            end
                            if (add_ok) begin
                                sum_next   = sum_ext[31:0];
                                count_next = count_reg + 8'd1;
                            end
                        end
                    end
                    if ((s_data.cmd == CMD_READ) && idx_in_chain) begin
                        rot_cnt_next = CW'(CELLS);
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    if (close_reg) begin
                        chain_push      = 1'b1;
                        chain_shift     = 1'b1;
                        push_entry.dose = div_q;
                        push_entry.date = wdate_reg;
                        live_dose_next  = div_q;
                        live_date_next  = '0;
                        flag_next       = 1'b1;
                        sum_next        = '0;
                        count_next      = '0;
                        wdate_next      = '0;
                    end else if ((live_dose_reg != div_q) || (live_date_reg == '0)) begin
                        if (live_date_reg == '0) begin
                            live_date_next = wdate_reg;
                        end
                        live_dose_next = div_q;
                        flag_next      = 1'b1;
                    end
                end
            end
            ST_ROTATE: begin
                chain_shift = 1'b1;
                if (32'(rot_cnt_reg) == 32'(in_reg.entry_index)) begin
                    pick_next = cell_q[CELLS];
                end
                rot_cnt_next = rot_cnt_reg - CW'(1);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    if (in_reg.cmd == CMD_CLEAR) begin
                        flag_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            live_dose_reg <= '0;
            live_date_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            wdate_reg     <= '0;
            flag_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            live_dose_reg <= live_dose_next;
            live_date_reg <= live_date_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            wdate_reg     <= wdate_next;
            flag_reg      <= flag_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        close_reg   <= close_next;
        rot_cnt_reg <= rot_cnt_next;
        pick_reg    <= pick_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide state");

    a_empty_window_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("window sum held without samples");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIVIDE) && div_done && close_reg)
            |=> ((count_reg == '0) && (wdate_reg == '0) && (live_date_reg == '0)))
        else $error("window not cleared after close");

    a_rotate_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROTATE) |-> (rot_cnt_reg != '0))
        else $error("rotation counter ran out");

endmodule

[hdl/dahl_cell.sv]
// ----------------------------------------------------------------------------
// dahl_cell
// one history entry of the shift chain, loads its neighbour when shifting
// ----------------------------------------------------------------------------
module dahl_cell
    import dahl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t d_in,
    output entry_t q
);

    entry_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

[hdl/dahl_div.sv]
// ----------------------------------------------------------------------------
// dahl_div
// restoring divider, 32-bit sum by 8-bit count, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dahl_div
    import dahl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       quo_reg;
    logic [7:0]        rem_reg;
    logic [7:0]        div_reg;
    logic [8:0]        trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == STEP_W'(DIV_STEPS - 1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            quo_reg  <= {quo_reg[30:0], fits};
            rem_reg  <= fits ? 8'(trial - {1'b0, div_reg}) : trial[7:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[tb/sv/tb_dose_average_history_log.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dose_average_history_log
// self-checking bench for the averaged dose history log
// ----------------------------------------------------------------------------
// Ticks, entry reads, flag reads and the spare command are driven over the
// valid/ready input channel. A tracker keeps its own copy of the window and
// history state and queues the word each input should produce. Output words
// are compared field by field in order. Both sides idle in random bursts. The
// stimulus starts with a directed part for the wrap, drop, count-limit and
// window-close cases, then runs random minute sequences mixed with reads and
// noise.
// ----------------------------------------------------------------------------
import dahl_pkg::*;

class dose_log_tracker;
    logic [31:0] hist_dose [HISTORY_POINTS_DEF];
    logic [31:0] hist_date [HISTORY_POINTS_DEF];
    logic [31:0] win_sum;
    logic [7:0]  win_count;
    logic [31:0] win_date;
    logic        flag_set;
    out_t        due_words [$];
    int unsigned errors;

    function new();
        for (int i = 0; i < HISTORY_POINTS_DEF; i++) begin
            hist_dose[i] = '0;
            hist_date[i] = '0;
        end
        win_sum   = '0;
        win_count = '0;
        win_date  = '0;
        flag_set  = 1'b0;
        errors    = 0;
    endfunction

    function int outstanding();
        return due_words.size();
    endfunction

    function void note_word(in_t w);
        out_t        r;
        logic [31:0] grown;
        logic [31:0] avg;
        if (w.cmd == CMD_TICK) begin
            if (w.seconds % WINDOW_PERIOD != 0) begin
                if (win_date == 32'd0) begin
                    win_date = w.date_now;
                end
                grown = win_sum + w.dose_sample;
                if (w.dose_sample != 32'd0 && grown > win_sum && win_count < COUNT_LIMIT) begin
                    win_sum   = grown;
                    win_count = win_count + 8'd1;
                    avg       = win_sum / win_count;
                    if (hist_dose[0] != avg || hist_date[0] == 32'd0) begin
                        if (hist_date[0] == 32'd0) begin
                            hist_date[0] = win_date;
                        end
                        hist_dose[0] = avg;
                        flag_set     = 1'b1;
                    end
                end
            end else if (win_count != 8'd0) begin
                avg = win_sum / win_count;
                for (int i = HISTORY_POINTS_DEF - 2; i >= 1; i--) begin
                    hist_dose[i + 1] = hist_dose[i];
                    hist_date[i + 1] = hist_date[i];
                end
                hist_dose[1] = avg;
                hist_date[1] = win_date;
                hist_dose[0] = avg;
                hist_date[0] = '0;
                flag_set     = 1'b1;
                win_sum      = '0;
                win_count    = '0;
                win_date     = '0;
            end
        end
        r.entry_dose = hist_dose[0];
        r.entry_date = hist_date[0];
        r.changed    = flag_set;
        if (w.cmd == CMD_READ) begin
            if (w.entry_index < HISTORY_POINTS_DEF) begin
                r.entry_dose = hist_dose[w.entry_index];
                r.entry_date = hist_date[w.entry_index];
            end else begin
                r.entry_dose = '0;
                r.entry_date = '0;
            end
        end else if (w.cmd == CMD_CLEAR) begin
            flag_set = 1'b0;
        end
        due_words.push_back(r);
    endfunction

    function void check_word(out_t got);
        out_t want;
        if (due_words.size() == 0) begin
            $error("unexpected word: dose %h date %h changed %b",
                   got.entry_dose, got.entry_date, got.changed);
            errors++;
            return;
        end
        want = due_words.pop_front();
        if (got.entry_dose !== want.entry_dose) begin
            $error("entry_dose: expected %h, got %h", want.entry_dose, got.entry_dose);
            errors++;
        end
        if (got.entry_date !== want.entry_date) begin
            $error("entry_date: expected %h, got %h", want.entry_date, got.entry_date);
            errors++;
        end
        if (got.changed !== want.changed) begin
            $error("changed: expected %b, got %b", want.changed, got.changed);
            errors++;
        end
    endfunction
endclass

module tb_dose_average_history_log;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int SETTLE_CYCLES      = 150;
    localparam int RANDOM_WORDS       = 200;
    localparam int CALM_WORDS         = 60;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    dose_log_tracker tracker = new();

    bit          calm = 1'b0;
    int unsigned words_sent = 0;
    int unsigned stall_cycles = 0;
    logic [31:0] clock_date;

    dose_average_history_log uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && aresetn && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_word(s_data);
            end
            if (m_valid && m_ready) begin
                tracker.check_word(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_dose_average_history_log: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic in_t random_word();
        in_t w;
        w.cmd         = 2'($urandom_range(0, 3));
        w.seconds     = 6'($urandom_range(0, 63));
        w.dose_sample = $urandom;
        w.date_now    = $urandom;
        w.entry_index = 6'($urandom_range(0, 63));
        return w;
    endfunction

    function automatic in_t tick_word(logic [5:0] secs, logic [31:0] sample,
                                      logic [31:0] stamp);
        in_t w;
        w             = random_word();
        w.cmd         = CMD_TICK;
        w.seconds     = secs;
        w.dose_sample = sample;
        w.date_now    = stamp;
        return w;
    endfunction

    function automatic in_t cmd_word(logic [1:0] op, logic [5:0] idx);
        in_t w;
        w             = random_word();
        w.cmd         = op;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    function automatic logic [31:0] pick_date();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return $urandom;
            default: return clock_date;
        endcase
    endfunction

    task automatic send_word(input in_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
    endtask

    task automatic send_read();
        case ($urandom_range(0, 3))
            0: send_word(cmd_word(CMD_CLEAR, 6'($urandom_range(0, 63))));
            1: send_word(cmd_word(CMD_SPARE, 6'($urandom_range(0, 63))));
            default: send_word(cmd_word(CMD_READ, 6'($urandom_range(0, 63))));
        endcase
    endtask

    // consecutive seconds with random samples, usually crossing a window end
    task automatic run_minute();
        int          len;
        logic [5:0]  secs;
        len  = $urandom_range(2, 14);
        secs = 6'($urandom_range(0, 59));
        repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
                send_read();
            end
            if ($urandom_range(0, 9) == 0) begin
                secs = 6'($urandom_range(60, 63));
            end
            send_word(tick_word(secs, pick_sample(), pick_date()));
            clock_date = clock_date + 32'd1;
            secs       = (secs >= 6'd59) ? 6'd0 : secs + 6'd1;
        end
    endtask

    // one window long enough to saturate the sample count
    task automatic run_long_window();
        logic [5:0] secs;
        repeat (270) begin
            secs = 6'($urandom_range(0, 63));
            if (secs % WINDOW_PERIOD == 0) begin
                secs = secs + 6'd1;
            end
            send_word(tick_word(secs, $urandom_range(1, 100), clock_date));
            clock_date = clock_date + 32'd1;
        end
        send_word(cmd_word(CMD_READ, 6'd0));
        send_word(tick_word(6'd10, $urandom, clock_date));
        send_word(cmd_word(CMD_READ, 6'd1));
    endtask

    initial begin
        int unsigned goal;
        clock_date = $urandom_range(1, 32'h7FFF_FFFF);
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        send_word(cmd_word(CMD_CLEAR, 6'd0));
        send_word(cmd_word(CMD_READ, 6'd0));
        send_word(cmd_word(CMD_READ, 6'd63));
        send_word('1);
        send_word(tick_word(6'd0, 32'd50, 32'h0000_1000));
        send_word(tick_word(6'd1, 32'd0, 32'h0000_1001));
        send_word(tick_word(6'd2, 32'hFFFF_FFFF, 32'h0000_1002));
        send_word(tick_word(6'd3, 32'd1, 32'h0000_1003));
        send_word(tick_word(6'd63, 32'd16, 32'h0000_1004));
        send_word(tick_word(6'd5, 32'd0, 32'h0000_1005));
        send_word(cmd_word(CMD_CLEAR, 6'd0));
        send_word(cmd_word(CMD_CLEAR, 6'd0));
        send_word(cmd_word(CMD_READ, 6'd1));
        send_word(tick_word(6'd61, 32'd7, 32'h0000_0000));
        send_word(tick_word(6'd62, 32'd9, 32'hFFFF_FFFF));
        send_word(tick_word(6'd60, 32'd4, 32'h0000_2000));
        send_word(tick_word(6'd59, 32'd3, 32'h0000_3000));
        send_word(cmd_word(CMD_CLEAR, 6'd0));
        send_word(tick_word(6'd57, 32'd3, 32'h0000_3001));
        send_word(cmd_word(CMD_CLEAR, 6'd0));
        send_word(tick_word(6'd55, 32'd3, 32'h0000_3002));
        send_word(cmd_word(CMD_READ, 6'd2));
        send_word(cmd_word(CMD_READ, 6'd3));
        send_word(cmd_word(CMD_SPARE, 6'd0));
        drain_results();

        run_long_window();
        drain_results();

        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            calm = (words_sent + CALM_WORDS >= goal);
            case ($urandom_range(0, 19))
                0, 1, 2: send_word(random_word());
                3: begin
                    if (!calm) begin
                        drain_results();
                    end
                end
                default: run_minute();
            endcase
        end
        calm = 1'b1;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb_dose_average_history_log: PASS");
        end else begin
            $display("tb_dose_average_history_log: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/dahl_pkg.sv
hdl/dahl_cell.sv
hdl/dahl_div.sv
hdl/dose_average_history_log.sv
tb/sv/tb_dose_average_history_log.sv
